/* rtl/core/iqpa_pkg.sv */
// ----------------------------------------------------------------------------
// iqpa_pkg
// Shared widths, constants and the arctangent table for the I/Q to
// phase and amplitude pipeline.
// ----------------------------------------------------------------------------
package iqpa_pkg;

  // CORDIC datapath widths
  localparam int XY_W = 44;   // x/y: sample << 24 plus CORDIC growth
  localparam int Z_W  = 34;   // Q30 angle accumulator with headroom
  localparam int ZC_W = 33;   // clamped angle, fits +/-pi in Q30

  localparam int ATAN_LEN = 24;

  localparam logic signed [Z_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

  // round(23040/pi * 2^16)
  localparam logic signed [29:0] DEG_PER_RAD_K = 30'sd480631834;

  localparam logic signed [19:0] HALF_TURN  = 20'sd23040;
  localparam logic signed [19:0] FULL_TURN  = 20'sd46080;
  localparam logic signed [19:0] TWO_PI_Q13 = 20'sd51472;

  // 25600^2, scales the squared magnitude to 1/256 percent before the root
  localparam logic [29:0] MAG_SCALE = 30'd655360000;
  localparam logic [30:0] MAG_ROUND = 31'd16383;

  // Fixed latencies of the post-CORDIC and magnitude units
  localparam int PHASE_LAT = 4;
  localparam int SQ_STEPS  = 31;
  localparam int MAG_LAT   = 3 + SQ_STEPS + 2;

  typedef struct packed {
    logic [17:0] phase_radians;
    logic [15:0] amplitude_percent;
    logic [17:0] phase_degrees;
  } result_t;

  // atan(2^-k) * 2^30, truncated
  function automatic logic [Z_W-1:0] atan_q30(input logic [4:0] idx);
    logic [Z_W-1:0] val;
    case (idx)
      5'd0:    val = 34'd843314856;
      5'd1:    val = 34'd497837829;
      5'd2:    val = 34'd263043836;
      5'd3:    val = 34'd133525158;
      5'd4:    val = 34'd67021686;
      5'd5:    val = 34'd33543515;
      5'd6:    val = 34'd16775850;
      5'd7:    val = 34'd8388437;
      5'd8:    val = 34'd4194282;
      5'd9:    val = 34'd2097149;
      5'd10:   val = 34'd1048575;
      5'd11:   val = 34'd524287;
      5'd12:   val = 34'd262143;
      5'd13:   val = 34'd131071;
      5'd14:   val = 34'd65535;
      5'd15:   val = 34'd32767;
      5'd16:   val = 34'd16383;
      5'd17:   val = 34'd8191;
      5'd18:   val = 34'd4095;
      5'd19:   val = 34'd2047;
      5'd20:   val = 34'd1023;
      5'd21:   val = 34'd511;
      5'd22:   val = 34'd255;
      5'd23:   val = 34'd127;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

/* rtl/core/iqpa_delay.sv */
// ----------------------------------------------------------------------------
// iqpa_delay
// Enable-gated delay line that aligns the shorter datapath with the longer.
// ----------------------------------------------------------------------------
module iqpa_delay #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  if (DEPTH == 0) begin : g_none
    assign q = d;
  end else begin : g_line
    logic [WIDTH-1:0] tap_r [0:DEPTH-1];

    always_ff @(posedge clk) begin
      if (en) begin
        tap_r[0] <= d;
        for (int k = 1; k < DEPTH; k++) begin
          tap_r[k] <= tap_r[k-1];
        end
      end
    end

    assign q = tap_r[DEPTH-1];
  end

endmodule

/* rtl/core/iqpa_cordic.sv */
// ----------------------------------------------------------------------------
// iqpa_cordic
// Vectoring CORDIC, one register stage for the quadrant fold and one per
// micro-rotation. Produces the raw Q30 angle and a zero-vector flag.
// ----------------------------------------------------------------------------
module iqpa_cordic #(
  parameter int STAGES = 16
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [15:0]                 i_sample,
  input  logic signed [15:0]                 q_sample,
  output logic signed [iqpa_pkg::Z_W-1:0]    z_out,
  output logic                               zero_out
);
  import iqpa_pkg::*;

  logic signed [XY_W-1:0] x_r    [0:STAGES];
  logic signed [XY_W-1:0] y_r    [0:STAGES];
  logic signed [Z_W-1:0]  z_r    [0:STAGES];
  logic                   zero_r [0:STAGES];

  logic signed [XY_W-1:0] xi;
  logic signed [XY_W-1:0] yq;
  logic signed [XY_W-1:0] x0_nxt;
  logic signed [XY_W-1:0] y0_nxt;
  logic signed [Z_W-1:0]  z0_nxt;

  assign xi = {{(XY_W-40){i_sample[15]}}, i_sample, 24'b0};
  assign yq = {{(XY_W-40){q_sample[15]}}, q_sample, 24'b0};

  // fold the left half-plane onto the right by a quarter turn
  always_comb begin
    x0_nxt = xi;
    y0_nxt = yq;
    z0_nxt = '0;
    if (i_sample[15]) begin
      if (!q_sample[15]) begin
        x0_nxt = yq;
        y0_nxt = -xi;
        z0_nxt = HALF_PI_Q30;
      end else begin
        x0_nxt = -yq;
        y0_nxt = xi;
        z0_nxt = -HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x0_nxt;
      y_r[0]    <= y0_nxt;
      z_r[0]    <= z0_nxt;
      zero_r[0] <= (i_sample == 16'sd0) && (q_sample == 16'sd0);
    end
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_rot
    logic                   y_pos;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  da;

    // a zero y rotates the same way as a negative one
    assign y_pos = !y_r[k][XY_W-1] && (y_r[k] != '0);
    assign dx    = y_r[k] >>> k;
    assign dy    = x_r[k] >>> k;
    assign da    = $signed(atan_q30(5'(k)));

    always_ff @(posedge clk) begin
      if (en) begin
        if (y_pos) begin
          x_r[k+1] <= x_r[k] + dx;
          y_r[k+1] <= y_r[k] - dy;
          z_r[k+1] <= z_r[k] + da;
        end else begin
          x_r[k+1] <= x_r[k] - dx;
          y_r[k+1] <= y_r[k] + dy;
          z_r[k+1] <= z_r[k] - da;
        end
        zero_r[k+1] <= zero_r[k];
      end
    end
  end

  assign z_out    = z_r[STAGES];
  assign zero_out = zero_r[STAGES];

endmodule

/* rtl/core/iqpa_phase.sv */
// ----------------------------------------------------------------------------
// iqpa_phase
// Angle post-processing: clamp, conversion to Q2.13 radians and 1/128
// degree, range shift and flip correction against the desired phase.
// ----------------------------------------------------------------------------
module iqpa_phase (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [iqpa_pkg::Z_W-1:0]    z_in,
  input  logic                               zero_in,
  input  logic signed [16:0]                 desired_phase,
  output logic signed [17:0]                 phase_degrees,
  output logic signed [17:0]                 phase_radians
);
  import iqpa_pkg::*;

  logic signed [ZC_W-1:0] zc_nxt;
  logic signed [ZC_W-1:0] zc_r;
  logic signed [46:0]     ph_r;
  logic        [44:0]     pl_r;
  logic signed [17:0]     rad_r;
  logic signed [17:0]     rad2_r;
  logic signed [17:0]     deg_r;
  logic signed [17:0]     deg_out_r;
  logic signed [17:0]     rad_out_r;

  logic signed [Z_W-1:0]  rad_sum;
  logic signed [62:0]     prod;
  logic signed [19:0]     dp;
  logic signed [19:0]     deg_sh;
  logic signed [19:0]     rad_sh;
  logic signed [19:0]     diff;
  logic signed [19:0]     deg_fix;

  // stage 1: clamp to [-pi, pi], zero vector gives zero
  always_comb begin
    if (zero_in) begin
      zc_nxt = '0;
    end else if (z_in > PI_Q30) begin
      zc_nxt = PI_Q30[ZC_W-1:0];
    end else if (z_in < -PI_Q30) begin
      zc_nxt = ZC_W'(-PI_Q30);
    end else begin
      zc_nxt = z_in[ZC_W-1:0];
    end
  end

  // stage 2: split the degree product into two partial products
  assign rad_sum = Z_W'(zc_r) + 34'sd65536;

  // stage 3: sum partials and round half up at bit 46
  assign prod = $signed({ph_r, 16'b0}) + $signed({18'b0, pl_r}) + (63'sd1 <<< 45);

  // stage 4: range shift, then one flip toward the desired phase
  always_comb begin
    dp     = 20'(desired_phase);
    deg_sh = 20'(deg_r);
    rad_sh = 20'(rad2_r);
    if (dp >= HALF_TURN) begin
      deg_sh = deg_sh + FULL_TURN;
      rad_sh = rad_sh + TWO_PI_Q13;
    end
    if (dp <= -HALF_TURN) begin
      deg_sh = deg_sh - FULL_TURN;
      rad_sh = rad_sh - TWO_PI_Q13;
    end
    diff    = dp - deg_sh;
    deg_fix = deg_sh;
    if (diff > HALF_TURN) begin
      deg_fix = deg_sh + FULL_TURN;
    end
    if (diff < -HALF_TURN) begin
      deg_fix = deg_sh - FULL_TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zc_r      <= zc_nxt;
      ph_r      <= $signed(zc_r[ZC_W-1:16]) * DEG_PER_RAD_K;
      pl_r      <= zc_r[15:0] * DEG_PER_RAD_K[28:0];
      rad_r     <= {rad_sum[Z_W-1], rad_sum[Z_W-1:17]};
      rad2_r    <= rad_r;
      deg_r     <= {prod[62], prod[62:46]};
      deg_out_r <= deg_fix[17:0];
      rad_out_r <= rad_sh[17:0];
    end
  end

  assign phase_degrees = deg_out_r;
  assign phase_radians = rad_out_r;

endmodule

/* rtl/core/iqpa_mag.sv */
// ----------------------------------------------------------------------------
// iqpa_mag
// Magnitude in 1/256 percent of full scale: squares, scaling multiply,
// one-bit-per-stage integer square root and rounded divide by 32767.
// ----------------------------------------------------------------------------
module iqpa_mag (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] i_sample,
  input  logic signed [15:0] q_sample,
  output logic        [15:0] amplitude_percent
);
  import iqpa_pkg::*;

  logic signed [31:0] ii_nxt;
  logic signed [31:0] qq_nxt;
  logic        [30:0] ii_r;
  logic        [30:0] qq_r;
  logic        [31:0] s_r;
  logic        [61:0] rdc0_r;

  logic        [31:0] rem_r  [0:SQ_STEPS-1];
  logic        [30:0] root_r [0:SQ_STEPS-1];
  logic        [61:0] rdc_r  [0:SQ_STEPS-1];

  logic        [30:0] n_r;
  logic        [62:0] quo;
  logic        [15:0] amp_r;

  assign ii_nxt = i_sample * i_sample;
  assign qq_nxt = q_sample * q_sample;

  always_ff @(posedge clk) begin
    if (en) begin
      ii_r   <= ii_nxt[30:0];
      qq_r   <= qq_nxt[30:0];
      s_r    <= 32'(ii_r) + 32'(qq_r);
      rdc0_r <= s_r * MAG_SCALE;
    end
  end

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
    logic [31:0] rem_in;
    logic [30:0] root_in;
    logic [61:0] rdc_in;
    logic [33:0] cur;
    logic [33:0] trial;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rdc_in  = rdc0_r;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign rdc_in  = rdc_r[j-1];
    end

    // bring down the next two radicand bits and try the next root bit
    assign cur   = {rem_in, rdc_in[61:60]};
    assign trial = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (cur >= trial) begin
          rem_r[j]  <= 32'(cur - trial);
          root_r[j] <= {root_in[29:0], 1'b1};
        end else begin
          rem_r[j]  <= cur[31:0];
          root_r[j] <= {root_in[29:0], 1'b0};
        end
        rdc_r[j] <= {rdc_in[59:0], 2'b00};
      end
    end
  end

  // n / 32767 for n < 2^31: n * (2^31 + 2^16 + 3) >> 46
  assign quo = 63'({n_r, 31'b0}) + 63'({n_r, 16'b0}) + 63'({n_r, 1'b0}) + 63'(n_r);

  always_ff @(posedge clk) begin
    if (en) begin
      n_r   <= root_r[SQ_STEPS-1] + MAG_ROUND;
      amp_r <= quo[61:46];
    end
  end

  assign amplitude_percent = amp_r;

endmodule

/* rtl/core/iq_to_phase_amplitude_unwrap.sv */
// ----------------------------------------------------------------------------
// iq_to_phase_amplitude_unwrap
// Phase (radians and degrees) and amplitude of signed 16-bit I/Q samples.
// ----------------------------------------------------------------------------
// Fully pipelined: one I/Q item is accepted every clock while in_tready is
// high, and each item gives one result item. PIPE_LAT is the depth of the
// longer of the two paths. The magnitude path is a 31-stage square root that
// resolves one root bit per stage and, at the default of 16 CORDIC stages,
// is the longer one. The angle path is one quadrant-fold stage, CORDIC_STAGES
// micro-rotation stages and four conversion stages; the shorter path is
// delayed to match. A two-entry output stage keeps in_tready registered, so
// back-pressure on the output reaches the input through the registered skid
// flag without losing an item. desired_phase is written through
// cfg_wr_en/cfg_wr_data and must only change while no item is in flight.
// ----------------------------------------------------------------------------
module iq_to_phase_amplitude_unwrap #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data,   // desired_phase

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,      // [15:0] i_sample, [31:16] q_sample

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata      // [17:0] phase_degrees,
                                     // [33:18] amplitude_percent,
                                     // [51:34] phase_radians, [55:52] zero
);
  import iqpa_pkg::*;

  localparam int ANG_LAT  = CORDIC_STAGES + 1 + PHASE_LAT;
  localparam int PIPE_LAT = (ANG_LAT > MAG_LAT) ? ANG_LAT : MAG_LAT;
  localparam int ANG_DLY  = PIPE_LAT - ANG_LAT;
  localparam int MAG_DLY  = PIPE_LAT - MAG_LAT;

  logic signed [16:0]    desired_phase_r;
  logic                  en;
  logic [PIPE_LAT-1:0]   vld_r;

  logic signed [15:0]    i_sample;
  logic signed [15:0]    q_sample;
  logic signed [Z_W-1:0] z_raw;
  logic                  z_zero;
  logic signed [17:0]    deg;
  logic signed [17:0]    rad;
  logic [15:0]           amp;
  logic [35:0]           ang_al;
  logic [15:0]           amp_al;

  result_t               pipe_res;
  result_t               out_r;
  result_t               skid_r;
  logic                  out_valid_r;
  logic                  skid_valid_r;
  logic                  pipe_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desired_phase_r <= '0;
    end else if (cfg_wr_en) begin
      desired_phase_r <= cfg_wr_data;
    end
  end

  // the pipeline advances whenever the output stage has room for one more
  assign en        = !skid_valid_r;
  assign in_tready = en;

  assign i_sample = in_tdata[15:0];
  assign q_sample = in_tdata[31:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_tvalid};
    end
  end

  iqpa_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk      (clk),
    .en       (en),
    .i_sample (i_sample),
    .q_sample (q_sample),
    .z_out    (z_raw),
    .zero_out (z_zero)
  );

  iqpa_phase u_phase (
    .clk           (clk),
    .en            (en),
    .z_in          (z_raw),
    .zero_in       (z_zero),
    .desired_phase (desired_phase_r),
    .phase_degrees (deg),
    .phase_radians (rad)
  );

  iqpa_mag u_mag (
    .clk               (clk),
    .en                (en),
    .i_sample          (i_sample),
    .q_sample          (q_sample),
    .amplitude_percent (amp)
  );

  iqpa_delay #(
    .WIDTH (36),
    .DEPTH (ANG_DLY)
  ) u_ang_dly (
    .clk (clk),
    .en  (en),
    .d   ({rad, deg}),
    .q   (ang_al)
  );

  iqpa_delay #(
    .WIDTH (16),
    .DEPTH (MAG_DLY)
  ) u_mag_dly (
    .clk (clk),
    .en  (en),
    .d   (amp),
    .q   (amp_al)
  );

  assign pipe_valid                 = vld_r[PIPE_LAT-1];
  assign pipe_res.phase_degrees     = ang_al[17:0];
  assign pipe_res.phase_radians     = ang_al[35:18];
  assign pipe_res.amplitude_percent = amp_al;

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_tready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= pipe_valid;
      end
    end else if (pipe_valid && en) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_valid_r) begin
      out_r <= skid_valid_r ? skid_r : pipe_res;
    end else if (pipe_valid && en) begin
      skid_r <= pipe_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_r.phase_radians, out_r.amplitude_percent,
                       out_r.phase_degrees};

endmodule
